// ===== rtl/twg_pkg.sv =====
// ----------------------------------------------------------------------------
// twg_pkg: shared types and constants of the table waveform generator
// Register indexes, configuration record, the waveform ROM and the
// arithmetic constants of the sample scaling.
// ----------------------------------------------------------------------------
package twg_pkg;

  // Fixed field widths.
  localparam int TABLE_POINTS = 50;
  localparam int SAMPLE_W     = 16;
  localparam int INDEX_W      = 6;
  localparam int POS_W        = 8;   // holds any point position up to 256 points
  localparam int CFG_DATA_W   = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WAVE_SELECT,
    REG_AMP_CODE,
    REG_MEAN_CODE,
    REG_STEP_PERIOD
  } twg_reg_t;

  // Waveform codes.
  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_SQUARE,
    WAVE_SAWTOOTH,
    WAVE_TRIANGLE
  } twg_wave_t;

  typedef struct packed {
    twg_wave_t   wave_select;
    logic [10:0] amp_code;
    logic [8:0]  mean_code;
    logic [15:0] step_period;
  } twg_cfg_t;

  localparam twg_wave_t   WAVE_SELECT_RST = WAVE_SINE;
  localparam logic [10:0] AMP_CODE_RST    = 11'd256;
  localparam logic [8:0]  MEAN_CODE_RST   = 9'd256;
  localparam logic [15:0] STEP_PERIOD_RST = 16'd20000;

  // Point request from the sequencer to the sample pipeline.
  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] pos;
    logic             last;
  } twg_point_t;

  // Sample scaling: floor((3*t*amp + 32767*(2*mean + 768)) / 1280).
  // The divide by 1280 is a shift by 8 and then a divide by 5, done as a
  // multiply by ceil(2^22 / 5); this is exact for dividends below 2^22.
  localparam logic [10:0] MEAN_BIAS  = 11'd768;
  localparam logic [19:0] RECIP5     = 20'd838861;
  localparam int          DIV5_SHIFT = 22;

  // Signed table contents: sine, square, sawtooth, triangle.
  localparam logic signed [15:0] WAVE_ROM [0:3][0:TABLE_POINTS-1] = '{
    '{ 16'sd0,     16'sd821,   16'sd1629,  16'sd2412,  16'sd3157,
       16'sd3852,  16'sd4486,  16'sd5049,  16'sd5533,  16'sd5930,
       16'sd6232,  16'sd6437,  16'sd6540,  16'sd6540,  16'sd6437,
       16'sd6232,  16'sd5928,  16'sd5532,  16'sd5048,  16'sd4484,
       16'sd3850,  16'sd3155,  16'sd2410,  16'sd1627,  16'sd818,
      -16'sd2,    -16'sd824,  -16'sd1632, -16'sd2415, -16'sd3159,
      -16'sd3854, -16'sd4488, -16'sd5051, -16'sd5535, -16'sd5931,
      -16'sd6233, -16'sd6438, -16'sd6540, -16'sd6540, -16'sd6436,
      -16'sd6231, -16'sd5927, -16'sd5530, -16'sd5046, -16'sd4482,
      -16'sd3848, -16'sd3152, -16'sd2407, -16'sd1624, -16'sd816 },
    '{ 16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,
       16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,
       16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,
       16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,
       16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,  16'sd6553,
       16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553,
      -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553,
      -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553,
      -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553,
      -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553, -16'sd6553 },
    '{ 16'sd0,     16'sd262,   16'sd524,   16'sd786,   16'sd1048,
       16'sd1310,  16'sd1572,  16'sd1834,  16'sd2097,  16'sd2359,
       16'sd2621,  16'sd2883,  16'sd3145,  16'sd3407,  16'sd3669,
       16'sd3932,  16'sd4194,  16'sd4456,  16'sd4718,  16'sd4980,
       16'sd5242,  16'sd5504,  16'sd5766,  16'sd6029,  16'sd6291,
       16'sd6553, -16'sd6291, -16'sd6029, -16'sd5766, -16'sd5504,
      -16'sd5242, -16'sd4980, -16'sd4718, -16'sd4456, -16'sd4194,
      -16'sd3932, -16'sd3669, -16'sd3407, -16'sd3145, -16'sd2883,
      -16'sd2621, -16'sd2359, -16'sd2097, -16'sd1834, -16'sd1572,
      -16'sd1310, -16'sd1048, -16'sd786,  -16'sd524,  -16'sd262 },
    '{ 16'sd0,     16'sd524,   16'sd1048,  16'sd1572,  16'sd2097,
       16'sd2621,  16'sd3145,  16'sd3669,  16'sd4194,  16'sd4718,
       16'sd5242,  16'sd5766,  16'sd6291,  16'sd6291,  16'sd5766,
       16'sd5242,  16'sd4718,  16'sd4194,  16'sd3669,  16'sd3145,
       16'sd2621,  16'sd2097,  16'sd1572,  16'sd1048,  16'sd524,
       16'sd0,    -16'sd524,  -16'sd1048, -16'sd1572, -16'sd2097,
      -16'sd2621, -16'sd3145, -16'sd3669, -16'sd4194, -16'sd4718,
      -16'sd5242, -16'sd5766, -16'sd6291, -16'sd6291, -16'sd5766,
      -16'sd5242, -16'sd4718, -16'sd4194, -16'sd3669, -16'sd3145,
      -16'sd2621, -16'sd2097, -16'sd1572, -16'sd1048, -16'sd524 }
  };

  // Table lookup; positions past the end of the table read as zero.
  function automatic logic signed [15:0] wave_value(twg_wave_t sel,
                                                    logic [POS_W-1:0] pos);
    logic signed [15:0] value;
    value = '0;
    if (pos < POS_W'(TABLE_POINTS)) begin
      value = WAVE_ROM[sel][pos[5:0]];
    end
    return value;
  endfunction

endpackage

// ===== rtl/twg_if.sv =====
// ----------------------------------------------------------------------------
// twg_if: request channels of the table waveform generator
// Tick channel into the block and sample channel out of it, each with
// valid, ready and payload.
// ----------------------------------------------------------------------------
interface twg_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface twg_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] dac_sample;
  logic [5:0]  point_index;
  logic        period_end;

  modport source (output valid, output dac_sample, output point_index,
                  output period_end, input ready);
  modport sink   (input valid, input dac_sample, input point_index,
                  input period_end, output ready);
endinterface

// ===== rtl/table_waveform_generator_core.sv =====
// ----------------------------------------------------------------------------
// table_waveform_generator_core: table-driven DAC waveform generator
// Channels:
//   name      dir  payload                                  request
//   ticks     in   tick                                     one base tick
//   samples   out  dac_sample, point_index, period_end      one DAC point
//   cfg_*     in   cfg_index, cfg_data                      register write
// One tick is accepted per clock while the first stage can move. A sample
// reaches the output register through the stages in order: lookup and
// multiply, offset add, and the reciprocal divide by five each take one
// register stage, the first loading on the accepting edge.
// Reset clears the prescaler, the point position and all stage valid bits and
// loads the register defaults. When the output is stalled the stages fill
// up behind it; ticks are accepted for as long as the first stage can move.
// ----------------------------------------------------------------------------
module table_waveform_generator_core #(
  parameter int POINTS       = 50,
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [twg_pkg::CFG_DATA_W-1:0] cfg_data,
  twg_tick_if.sink                       ticks,
  twg_sample_if.source                   samples
);
  import twg_pkg::*;

  twg_cfg_t   cfg;
  twg_point_t point;
  logic       take;
  logic       accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_select <= WAVE_SELECT_RST;
      cfg.amp_code    <= AMP_CODE_RST;
      cfg.mean_code   <= MEAN_CODE_RST;
      cfg.step_period <= STEP_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (twg_reg_t'(cfg_index))
        REG_WAVE_SELECT: cfg.wave_select <= twg_wave_t'(cfg_data[1:0]);
        REG_AMP_CODE:    cfg.amp_code    <= cfg_data[10:0];
        REG_MEAN_CODE:   cfg.mean_code   <= cfg_data[8:0];
        REG_STEP_PERIOD: cfg.step_period <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Input request handshake.
  assign ticks.ready = take;
  assign accept      = ticks.valid && take;

  twg_sequencer #(
    .POINTS       (POINTS),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .tick        (ticks.tick),
    .step_period (cfg.step_period),
    .point       (point)
  );

  twg_sample_pipe u_sample_pipe (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .point   (point),
    .take    (take),
    .samples (samples)
  );

endmodule

// ===== rtl/twg_sequencer.sv =====
// ----------------------------------------------------------------------------
// twg_sequencer: tick prescaler and table point position
// Counts accepted ticks up to the step period, flags the tick on which a
// point is emitted and steps the point position with wrap.
// ----------------------------------------------------------------------------
module twg_sequencer #(
  parameter int POINTS       = 50,
  parameter int PERIOD_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               tick,
  input  logic [15:0]        step_period,
  output twg_pkg::twg_point_t point
);
  import twg_pkg::*;

  localparam int POS_BITS = $clog2(POINTS);
  localparam logic [POS_BITS:0] LAST_POS = (POS_BITS + 1)'(POINTS - 1);

  logic [PERIOD_WIDTH-1:0] tick_count;
  logic [PERIOD_WIDTH-1:0] tick_count_next;
  logic [POS_BITS-1:0]     point_pos;
  logic [POS_BITS-1:0]     point_pos_next;
  logic [PERIOD_WIDTH-1:0] period;
  logic [PERIOD_WIDTH-1:0] count_inc;
  logic [POS_BITS:0]       pos_inc;
  logic                    step;

  // A zero period behaves as one tick per point.
  always_comb begin
    period = PERIOD_WIDTH'(step_period);
    if (period == '0) begin
      period = PERIOD_WIDTH'(1);
    end
  end

  // Next counter and position on an accepted tick.
  always_comb begin
    count_inc       = tick_count + PERIOD_WIDTH'(1);
    pos_inc         = {1'b0, point_pos} + (POS_BITS + 1)'(1);
    step            = (count_inc >= period) || (count_inc == '0);
    tick_count_next = tick_count;
    point_pos_next  = point_pos;
    if (accept && tick) begin
      if (step) begin
        tick_count_next = '0;
        if (pos_inc > LAST_POS) begin
          point_pos_next = '0;
        end else begin
          point_pos_next = pos_inc[POS_BITS-1:0];
        end
      end else begin
        tick_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      point_pos  <= '0;
    end else begin
      tick_count <= tick_count_next;
      point_pos  <= point_pos_next;
    end
  end

  // A point is emitted on a tick that finds the prescaler at zero.
  assign point.emit = accept && tick && (tick_count == '0);
  assign point.pos  = POS_W'(point_pos);
  assign point.last = ({1'b0, point_pos} == LAST_POS);

endmodule

// ===== rtl/twg_sample_pipe.sv =====
// ----------------------------------------------------------------------------
// twg_sample_pipe: sample scaling pipeline
// Table lookup and amplitude multiply, offset add and shift, divide by five
// with clamp into the output register. Each stage moves on when the stage
// after it is empty or moving.
// ----------------------------------------------------------------------------
module twg_sample_pipe (
  input  logic                clk,
  input  logic                rst,
  input  twg_pkg::twg_cfg_t   cfg,
  input  twg_pkg::twg_point_t point,
  output logic                take,
  twg_sample_if.source        samples
);
  import twg_pkg::*;

  // Stage one: product of table value and amplitude.
  logic                      prod_valid;
  logic signed [27:0]        prod;
  logic [INDEX_W-1:0]        prod_index;
  logic                      prod_last;

  // Stage two: nonnegative numerator divided by 256.
  logic                      scaled_valid;
  logic [19:0]               scaled;
  logic [INDEX_W-1:0]        scaled_index;
  logic                      scaled_last;

  // Stage three: output register.
  logic                      out_valid;
  logic [SAMPLE_W-1:0]       out_sample;
  logic [INDEX_W-1:0]        out_index;
  logic                      out_last;

  logic                      out_free;
  logic                      scaled_free;
  logic                      prod_free;

  logic signed [15:0]        table_val;
  logic signed [27:0]        prod_next;
  logic [10:0]               bias;
  logic [29:0]               offset;
  logic signed [29:0]        triple;
  logic signed [29:0]        num;
  logic [19:0]               scaled_next;
  logic [39:0]               recip_prod;
  logic [17:0]               quot;
  logic [SAMPLE_W-1:0]       sample_next;

  // Handshake: a stage loads when the stage after it can take its item.
  assign out_free    = !out_valid || samples.ready;
  assign scaled_free = !scaled_valid || out_free;
  assign prod_free   = !prod_valid || scaled_free;
  assign take        = prod_free;

  // Lookup and multiply.
  always_comb begin
    table_val = wave_value(cfg.wave_select, point.pos);
    prod_next = 28'(table_val) * 28'($signed({1'b0, cfg.amp_code}));
  end

  // Offset add, clamp at zero and drop the low eight bits.
  always_comb begin
    bias   = 11'({cfg.mean_code, 1'b0}) + MEAN_BIAS;
    offset = (30'(bias) << 15) - 30'(bias);
    triple = (30'(prod) <<< 1) + 30'(prod);
    num    = triple + $signed(offset);
    if (num[29]) begin
      scaled_next = '0;
    end else begin
      scaled_next = num[27:8];
    end
  end

  // Divide by five through the reciprocal, then saturate to 16 bits.
  always_comb begin
    recip_prod = 40'(scaled) * 40'(RECIP5);
    quot       = recip_prod[DIV5_SHIFT +: 18];
    if (quot > 18'(16'hFFFF)) begin
      sample_next = '1;
    end else begin
      sample_next = quot[SAMPLE_W-1:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      scaled_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (prod_free) begin
        prod_valid <= point.emit;
      end
      if (scaled_free) begin
        scaled_valid <= prod_valid;
      end
      if (out_free) begin
        out_valid <= scaled_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (prod_free) begin
      prod       <= prod_next;
      prod_index <= INDEX_W'(point.pos);
      prod_last  <= point.last;
    end
    if (scaled_free) begin
      scaled       <= scaled_next;
      scaled_index <= prod_index;
      scaled_last  <= prod_last;
    end
    if (out_free) begin
      out_sample <= sample_next;
      out_index  <= scaled_index;
      out_last   <= scaled_last;
    end
  end

  assign samples.valid       = out_valid;
  assign samples.dac_sample  = out_sample;
  assign samples.point_index = out_index;
  assign samples.period_end  = out_last;

endmodule

// ===== tb/table_waveform_generator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_waveform_generator_core_tb: self-checking bench for the waveform core
// Drives tick requests and register writes, predicts every DAC sample with an
// independent copy of the prescaler, point counter and waveform tables, and
// compares each sample request leaving the core field by field.
// ----------------------------------------------------------------------------
import twg_pkg::*;

localparam int POINT_COUNT = 50;
localparam int PERIOD_W    = 16;
localparam int TABLE_LEN   = 50;

// Waveform shapes, one row per wave code, in the order of the code values.
localparam int SHAPE_TABLE [4][TABLE_LEN] = '{
  '{    0,   821,  1629,  2412,  3157,  3852,  4486,  5049,  5533,  5930,
     6232,  6437,  6540,  6540,  6437,  6232,  5928,  5532,  5048,  4484,
     3850,  3155,  2410,  1627,   818,    -2,  -824, -1632, -2415, -3159,
    -3854, -4488, -5051, -5535, -5931, -6233, -6438, -6540, -6540, -6436,
    -6231, -5927, -5530, -5046, -4482, -3848, -3152, -2407, -1624,  -816 },
  '{ 6553,  6553,  6553,  6553,  6553,  6553,  6553,  6553,  6553,  6553,
     6553,  6553,  6553,  6553,  6553,  6553,  6553,  6553,  6553,  6553,
     6553,  6553,  6553,  6553,  6553,  6553, -6553, -6553, -6553, -6553,
    -6553, -6553, -6553, -6553, -6553, -6553, -6553, -6553, -6553, -6553,
    -6553, -6553, -6553, -6553, -6553, -6553, -6553, -6553, -6553, -6553 },
  '{    0,   262,   524,   786,  1048,  1310,  1572,  1834,  2097,  2359,
     2621,  2883,  3145,  3407,  3669,  3932,  4194,  4456,  4718,  4980,
     5242,  5504,  5766,  6029,  6291,  6553, -6291, -6029, -5766, -5504,
    -5242, -4980, -4718, -4456, -4194, -3932, -3669, -3407, -3145, -2883,
    -2621, -2359, -2097, -1834, -1572, -1310, -1048,  -786,  -524,  -262 },
  '{    0,   524,  1048,  1572,  2097,  2621,  3145,  3669,  4194,  4718,
     5242,  5766,  6291,  6291,  5766,  5242,  4718,  4194,  3669,  3145,
     2621,  2097,  1572,  1048,   524,     0,  -524, -1048, -1572, -2097,
    -2621, -3145, -3669, -4194, -4718, -5242, -5766, -6291, -6291, -5766,
    -5242, -4718, -4194, -3669, -3145, -2621, -2097, -1572, -1048,  -524 }
};

typedef struct {
  bit [15:0] dac;
  bit [5:0]  index;
  bit        last;
} dac_point_t;

// Tracks the generator state, queues the samples it predicts and checks
// the samples that come out of the core.
class dac_point_scoreboard;
  twg_wave_t          wave;
  bit [10:0]          amp;
  bit [8:0]           mean;
  bit [PERIOD_W-1:0]  period;
  bit [PERIOD_W-1:0]  tick_count;
  int unsigned        point_pos;
  dac_point_t         pending_points[$];
  int unsigned        mismatches;
  int unsigned        samples_seen;

  function void reset_state();
    wave       = WAVE_SINE;
    amp        = 11'd256;
    mean       = 9'd256;
    period     = PERIOD_W'(20000);
    tick_count = '0;
    point_pos  = 0;
    pending_points.delete();
  endfunction

  function void write_register(twg_reg_t idx, bit [15:0] data);
    case (idx)
      REG_WAVE_SELECT: wave   = twg_wave_t'(data[1:0]);
      REG_AMP_CODE:    amp    = data[10:0];
      REG_MEAN_CODE:   mean   = data[8:0];
      REG_STEP_PERIOD: period = data[PERIOD_W-1:0];
      default: ;
    endcase
  endfunction

  // floor((3*t*amp + 32767*(2*mean + 768)) / 1280), clamped to the DAC range.
  function bit [15:0] scaled_sample();
    longint level;
    longint num;
    longint quot;
    level = (point_pos < TABLE_LEN) ? longint'(SHAPE_TABLE[wave][point_pos]) : 0;
    num = 3 * level * longint'(amp) + 32767 * (2 * longint'(mean) + 768);
    if (num < 0) begin
      return 16'd0;
    end
    quot = num / 1280;
    if (quot > 65535) begin
      quot = 65535;
    end
    return 16'(quot);
  endfunction

  // One accepted tick request: emit when the prescaler reads zero, then
  // count and step to the next point once the period has elapsed.
  function void note_tick(bit tick);
    bit [PERIOD_W-1:0] limit;
    dac_point_t        point;
    if (!tick) begin
      return;
    end
    limit = (period == 0) ? PERIOD_W'(1) : period;
    if (tick_count == 0) begin
      point.dac   = scaled_sample();
      point.index = 6'(point_pos);
      point.last  = (point_pos == POINT_COUNT - 1);
      pending_points.push_back(point);
    end
    tick_count = tick_count + 1'b1;
    if (tick_count >= limit || tick_count == 0) begin
      tick_count = '0;
      point_pos  = point_pos + 1;
      if (point_pos >= POINT_COUNT) begin
        point_pos = 0;
      end
    end
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] error: %s", $time, msg);
    end
  endtask

  task check_sample(bit [15:0] dac, bit [5:0] index, bit last);
    dac_point_t want;
    samples_seen++;
    if (pending_points.size() == 0) begin
      report($sformatf("unexpected sample %0d at index %0d", dac, index));
      return;
    end
    want = pending_points.pop_front();
    if (dac != want.dac) begin
      report($sformatf("dac_sample %0d, expected %0d (index %0d)",
                       dac, want.dac, want.index));
    end
    if (index != want.index) begin
      report($sformatf("point_index %0d, expected %0d", index, want.index));
    end
    if (last != want.last) begin
      report($sformatf("period_end %0b, expected %0b at index %0d",
                       last, want.last, want.index));
    end
  endtask
endclass

module table_waveform_generator_core_tb;

  localparam int RANDOM_ITEMS = 800;
  localparam int PIPE_MARGIN  = 8;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  twg_tick_if   ticks_if ();
  twg_sample_if samples_if ();

  dac_point_scoreboard book;

  bit          gap_enable;
  bit          stall_enable;
  int unsigned items_sent;
  int unsigned idle_items;
  int unsigned settings_written;

  table_waveform_generator_core #(
    .POINTS       (POINT_COUNT),
    .PERIOD_WIDTH (PERIOD_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ticks     (ticks_if),
    .samples   (samples_if)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Sample receiver: ready toggles in random bursts at the falling edge.
  initial begin
    int unsigned hold;
    int unsigned burst;
    samples_if.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      hold = stall_enable ? pick_gap() : 0;
      repeat (hold) begin
        @(negedge clk);
        samples_if.ready = 1'b0;
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        @(negedge clk);
        samples_if.ready = 1'b1;
      end
    end
  end

  // Every sample request taken at a rising edge is checked.
  always @(posedge clk) begin
    if (rst === 1'b0 && samples_if.valid === 1'b1 && samples_if.ready === 1'b1) begin
      book.check_sample(samples_if.dac_sample, samples_if.point_index,
                        samples_if.period_end);
    end
  end

  // Offers one tick request, after an optional gap, and waits for it to go in.
  task automatic send_tick(input bit tick);
    int unsigned idle;
    idle = gap_enable ? pick_gap() : 0;
    repeat (idle) begin
      @(negedge clk);
      ticks_if.valid = 1'b0;
    end
    @(negedge clk);
    ticks_if.valid = 1'b1;
    ticks_if.tick  = tick;
    do @(posedge clk); while (ticks_if.ready !== 1'b1);
    book.note_tick(tick);
    if (tick) begin
      items_sent++;
    end else begin
      idle_items++;
    end
  endtask

  // Holds off the sender until every predicted sample has come out and the
  // pipeline has had time to empty.
  task automatic settle();
    @(negedge clk);
    ticks_if.valid = 1'b0;
    while (book.pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_MARGIN) @(posedge clk);
  endtask

  task automatic write_reg(input twg_reg_t idx, input bit [15:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    book.write_register(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
    settings_written++;
  endtask

  // Random register setting; edge values and codes past the documented
  // ranges come up now and then, sometimes with junk in the unused bits.
  task automatic pick_setting();
    bit [15:0]   data;
    int unsigned r;
    if ($urandom_range(0, 9) < 7) begin
      data = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
      data[1:0] = 2'($urandom_range(0, 3));
      write_reg(REG_WAVE_SELECT, data);
    end
    if ($urandom_range(0, 9) < 7) begin
      data = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
      r = $urandom_range(0, 19);
      if (r < 2) begin
        data[10:0] = 11'd0;
      end else if (r < 4) begin
        data[10:0] = 11'd1280;
      end else if (r == 4) begin
        data[10:0] = 11'($urandom_range(1281, 2047));
      end else begin
        data[10:0] = 11'($urandom_range(0, 1280));
      end
      write_reg(REG_AMP_CODE, data);
    end
    if ($urandom_range(0, 9) < 7) begin
      data = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
      r = $urandom_range(0, 19);
      if (r < 2) begin
        data[8:0] = 9'd0;
      end else if (r < 4) begin
        data[8:0] = 9'd256;
      end else if (r == 4) begin
        data[8:0] = 9'($urandom_range(257, 511));
      end else begin
        data[8:0] = 9'($urandom_range(0, 256));
      end
      write_reg(REG_MEAN_CODE, data);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 19);
      if (r < 2) begin
        data = 16'd0;
      end else if (r < 8) begin
        data = 16'd1;
      end else if (r < 15) begin
        data = 16'($urandom_range(2, 6));
      end else if (r < 19) begin
        data = 16'($urandom_range(7, 40));
      end else begin
        data = 16'($urandom_range(200, 400));
      end
      write_reg(REG_STEP_PERIOD, data);
    end
  endtask

  // Stimulus.
  initial begin
    int unsigned phase;
    int unsigned burst;
    int unsigned random_start;
    int unsigned k;
    book = new();
    book.reset_state();
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = REG_WAVE_SELECT;
    cfg_data         = 16'd0;
    ticks_if.valid   = 1'b0;
    ticks_if.tick    = 1'b0;
    gap_enable       = 1'b0;
    stall_enable     = 1'b0;
    items_sent       = 0;
    idle_items       = 0;
    settings_written = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: mid-scale sine with a long period, so only the first
    // tick emits; a request without a tick must do nothing.
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // Full-scale square; a zero period behaves as a period of one.
    write_reg(REG_WAVE_SELECT, 16'(WAVE_SQUARE));
    write_reg(REG_AMP_CODE, 16'd1280);
    write_reg(REG_MEAN_CODE, 16'd256);
    write_reg(REG_STEP_PERIOD, 16'd0);
    repeat (4) send_tick(1'b1);
    settle();

    // Zero amplitude and zero mean on the triangle, one point per tick.
    write_reg(REG_WAVE_SELECT, 16'(WAVE_TRIANGLE));
    write_reg(REG_AMP_CODE, 16'd0);
    write_reg(REG_MEAN_CODE, 16'd0);
    write_reg(REG_STEP_PERIOD, 16'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();

    // Codes past the documented ranges are written with all unused data bits set.
    write_reg(REG_WAVE_SELECT, {14'h3FFF, WAVE_SAWTOOTH});
    write_reg(REG_AMP_CODE, 16'hFFFF);
    write_reg(REG_MEAN_CODE, 16'hFFFF);
    write_reg(REG_STEP_PERIOD, 16'd2);
    repeat (4) send_tick(1'b1);
    settle();

    // Longest period: only the first tick of the point emits.
    write_reg(REG_STEP_PERIOD, 16'hFFFF);
    write_reg(REG_AMP_CODE, 16'd1280);
    write_reg(REG_MEAN_CODE, 16'd128);
    write_reg(REG_WAVE_SELECT, 16'(WAVE_SINE));
    repeat (3) send_tick(1'b1);
    settle();

    // Random phases, each with its own setting and idle pattern.
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS && phase < 400) begin
      settle();
      pick_setting();
      gap_enable   = ($urandom_range(0, 3) != 0);
      stall_enable = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(40, 120);
      for (k = 0; k < burst; k++) begin
        send_tick($urandom_range(0, 9) != 0);
        // Once in the run the sender waits for the output side to drain.
        if (phase == 4 && k == burst / 2) begin
          settle();
        end
      end
      phase++;
    end

    // Drain and let any stray sample show up.
    @(negedge clk);
    ticks_if.valid = 1'b0;
    for (k = 0; k < 5000 && book.pending_points.size() != 0; k++) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (book.pending_points.size() != 0) begin
      book.report($sformatf("%0d predicted samples never came out",
                            book.pending_points.size()));
    end

    $display("Covered %0d tick requests and %0d idle requests over %0d register writes,",
             items_sent, idle_items, settings_written);
    $display("with %0d samples checked across %0d random settings.",
             book.samples_seen, phase);
    if (book.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #6000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/twg_pkg.sv
rtl/twg_if.sv
rtl/twg_sequencer.sv
rtl/twg_sample_pipe.sv
rtl/table_waveform_generator_core.sv
tb/table_waveform_generator_core_tb.sv
